// ----- rtl/wfq_pkg.sv -----
// Shared types, constants and the queue ordering function of the WFQ tag scheduler.
// No dependencies; every other file imports this package.
package wfq_pkg;

   localparam int QDEPTH = 128;
   localparam int ADDR_W = $clog2(QDEPTH);
   localparam int CNT_W  = $clog2(QDEPTH + 1);
   localparam int TIME_W = 32;
   localparam int STEP_W = 24;
   localparam int LIMIT_W = 8;
   localparam int CSR_DW = 24;
   localparam int CSR_IW = 2;
   localparam int CMP_W  = 16;

   localparam logic [CSR_IW-1:0] CSR_QUEUE_LIMIT = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_STEP_FLOW0  = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_STEP_FLOW1  = 2'd2;

   localparam logic CMD_ARRIVE = 1'b0;
   localparam logic CMD_DONE   = 1'b1;

   typedef enum logic [2:0] {
      KIND_SERVED   = 3'd0,
      KIND_QUEUED   = 3'd1,
      KIND_DROPPED  = 3'd2,
      KIND_DEQUEUED = 3'd3,
      KIND_IDLE     = 3'd4
   } kind_type;

   typedef enum logic [4:0] {
      ST_IDLE        = 5'b00001,
      ST_INSERT      = 5'b00010,
      ST_INSERT_LAST = 5'b00100,
      ST_POP_HEAD    = 5'b01000,
      ST_POP_SHIFT   = 5'b10000
   } state_type;

   typedef struct packed {
      logic [TIME_W-1:0] tag;
      logic [TIME_W-1:0] arrival;
      logic              flow;
   } entry_type;

   // True when entry a sorts strictly before entry b.
   function automatic logic key_less(entry_type a, entry_type b);
      logic res;
      if (a.tag != b.tag) begin
         res = a.tag < b.tag;
      end else if (a.arrival != b.arrival) begin
         res = a.arrival < b.arrival;
      end else begin
         res = a.flow < b.flow;
      end
      return res;
   endfunction

endpackage

// ----- rtl/wfq_req_if.sv -----
// Request and response channel interfaces of the WFQ tag scheduler.
// Depends on wfq_pkg for the field widths.
interface wfq_req_if;
   import wfq_pkg::*;
   logic              valid;
   logic              ready;
   logic              cmd;
   logic              flow;
   logic [TIME_W-1:0] now_time;
   modport source (output valid, cmd, flow, now_time, input ready);
   modport sink (input valid, cmd, flow, now_time, output ready);
endinterface

interface wfq_rsp_if;
   import wfq_pkg::*;
   logic              valid;
   logic              ready;
   logic [2:0]        kind;
   logic              out_flow;
   logic [TIME_W-1:0] finish_tag;
   logic [TIME_W-1:0] wait_time;
   logic [7:0]        queue_count;
   logic [31:0]       dropped_count;
   modport source (output valid, kind, out_flow, finish_tag, wait_time, queue_count,
                   dropped_count, input ready);
   modport sink (input valid, kind, out_flow, finish_tag, wait_time, queue_count,
                 dropped_count, output ready);
endinterface

// ----- rtl/wfq_tag_scheduler.sv -----
// Top level of the two-flow WFQ tag scheduler with a sorted waiting queue in one RAM.
// Depends on wfq_pkg and the channel interfaces in wfq_req_if.sv.
//
// The req channel carries one event word: an arrival (cmd 0) of a packet of a
// given flow, or the completion (cmd 1) of the packet in service. Each event
// yields exactly one word on the rsp channel. The csr port writes the queue
// limit and the two per-flow tag steps; the user must write them only while the
// block is idle, which the block itself does not enforce.
// An arrival served at once, dropped, or queued into an empty queue, and a
// completion with an empty queue, answer in the cycle after acceptance.
// An arrival queued behind waiting words walks the sorted queue from its tail,
// and a dequeue shifts the remaining entries forward; one RAM entry is read and
// one written per cycle.
// A new word is accepted when the sequencer is idle and the result register
// is empty or being emptied in the same cycle, so a stalled receiver holds
// the result and blocks only the next event.
// Reset clears the counters, virtual time, flow tags and the busy flag and
// loads the register defaults; the queue RAM needs no clearing.
module wfq_tag_scheduler (
   input  logic                       clock,
   input  logic                       reset,
   wfq_req_if.sink                    req,
   wfq_rsp_if.source                  rsp,
   input  logic                       csr_we,
   input  logic [wfq_pkg::CSR_IW-1:0] csr_index,
   input  logic [wfq_pkg::CSR_DW-1:0] csr_wdata
);
   import wfq_pkg::*;

   entry_type mem [QDEPTH];
   entry_type rdata_ff;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   entry_type         wr_data;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TIME_W-1:0] vtime_ff, vtime_in;
   logic [TIME_W-1:0] last0_ff, last0_in, last1_ff, last1_in;
   logic              busy_ff, busy_in;
   logic [31:0]       drop_ff, drop_in;
   logic [LIMIT_W-1:0] qlimit_ff, qlimit_in;
   logic [STEP_W-1:0] step0_ff, step0_in, step1_ff, step1_in;
   entry_type         new_ff, new_in;

   logic              rsp_valid_ff, rsp_valid_in;
   kind_type          kind_ff, kind_in;
   logic              oflow_ff, oflow_in;
   logic [TIME_W-1:0] tag_ff, tag_in;
   logic [TIME_W-1:0] wait_ff, wait_in;
   logic [7:0]        qcount_ff, qcount_in;
   logic [31:0]       dcount_ff, dcount_in;

   logic              accept;
   logic [TIME_W-1:0] base;
   logic [TIME_W:0]   sum;
   logic [TIME_W-1:0] new_tag;
   logic              room;

   assign req.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.kind          = kind_ff;
   assign rsp.out_flow      = oflow_ff;
   assign rsp.finish_tag    = tag_ff;
   assign rsp.wait_time     = wait_ff;
   assign rsp.queue_count   = qcount_ff;
   assign rsp.dropped_count = dcount_ff;

   always_comb begin
      logic [TIME_W-1:0] last;
      logic [STEP_W-1:0] step;
      last = req.flow ? last1_ff : last0_ff;
      step = req.flow ? step1_ff : step0_ff;
      base = (vtime_ff > last) ? vtime_ff : last;
      sum = {1'b0, base} + {{(TIME_W + 1 - STEP_W){1'b0}}, step};
      new_tag = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
      room = (CMP_W'(count_ff) < CMP_W'(qlimit_ff)) && (CMP_W'(count_ff) < CMP_W'(QDEPTH));
   end

   always_comb begin
      state_in = state_ff;
      ptr_in = ptr_ff;
      count_in = count_ff;
      vtime_in = vtime_ff;
      last0_in = last0_ff;
      last1_in = last1_ff;
      busy_in = busy_ff;
      drop_in = drop_ff;
      qlimit_in = qlimit_ff;
      step0_in = step0_ff;
      step1_in = step1_ff;
      new_in = new_ff;
      rsp_valid_in = rsp_valid_ff;
      kind_in = kind_ff;
      oflow_in = oflow_ff;
      tag_in = tag_ff;
      wait_in = wait_ff;
      qcount_in = qcount_ff;
      dcount_in = dcount_ff;
      rd_en = 1'b0;
      rd_addr = '0;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = new_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_QUEUE_LIMIT: qlimit_in = csr_wdata[LIMIT_W-1:0];
            CSR_STEP_FLOW0:  step0_in = csr_wdata[STEP_W-1:0];
            CSR_STEP_FLOW1:  step1_in = csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               wait_in = '0;
               dcount_in = drop_ff;
               if (req.cmd == CMD_ARRIVE) begin
                  if (req.flow) begin
                     last1_in = new_tag;
                  end else begin
                     last0_in = new_tag;
                  end
                  new_in.tag = new_tag;
                  new_in.arrival = req.now_time;
                  new_in.flow = req.flow;
                  oflow_in = req.flow;
                  tag_in = new_tag;
                  if (!busy_ff) begin
                     busy_in = 1'b1;
                     kind_in = KIND_SERVED;
                     rsp_valid_in = 1'b1;
                     qcount_in = 8'(count_ff);
                  end else if (room) begin
                     kind_in = KIND_QUEUED;
                     if (count_ff == '0) begin
                        wr_en = 1'b1;
                        wr_addr = '0;
                        wr_data.tag = new_tag;
                        wr_data.arrival = req.now_time;
                        wr_data.flow = req.flow;
                        count_in = CNT_W'(1);
                        rsp_valid_in = 1'b1;
                        qcount_in = 8'd1;
                     end else begin
                        ptr_in = ADDR_W'(count_ff);
                        rd_en = 1'b1;
                        rd_addr = ADDR_W'(count_ff - CNT_W'(1));
                        state_in = ST_INSERT;
                     end
                  end else begin
                     if (drop_ff != 32'hFFFF_FFFF) begin
                        drop_in = drop_ff + 32'd1;
                     end
                     dcount_in = drop_in;
                     kind_in = KIND_DROPPED;
                     rsp_valid_in = 1'b1;
                     qcount_in = 8'(count_ff);
                  end
               end else begin
                  new_in.arrival = req.now_time;
                  if (count_ff == '0) begin
                     busy_in = 1'b0;
                     kind_in = KIND_IDLE;
                     oflow_in = 1'b0;
                     tag_in = '0;
                     rsp_valid_in = 1'b1;
                     qcount_in = '0;
                  end else begin
                     rd_en = 1'b1;
                     rd_addr = '0;
                     state_in = ST_POP_HEAD;
                  end
               end
            end
         end
         ST_INSERT: begin
            wr_en = 1'b1;
            if (key_less(new_ff, rdata_ff)) begin
               wr_addr = ptr_ff;
               wr_data = rdata_ff;
               ptr_in = ptr_ff - ADDR_W'(1);
               if (ptr_ff == ADDR_W'(1)) begin
                  state_in = ST_INSERT_LAST;
               end else begin
                  rd_en = 1'b1;
                  rd_addr = ptr_ff - ADDR_W'(2);
               end
            end else begin
               wr_addr = ptr_ff;
               wr_data = new_ff;
               count_in = count_ff + CNT_W'(1);
               qcount_in = 8'(count_in);
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_INSERT_LAST: begin
            wr_en = 1'b1;
            wr_addr = '0;
            wr_data = new_ff;
            count_in = count_ff + CNT_W'(1);
            qcount_in = 8'(count_in);
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_POP_HEAD: begin
            kind_in = KIND_DEQUEUED;
            oflow_in = rdata_ff.flow;
            tag_in = rdata_ff.tag;
            wait_in = (new_ff.arrival >= rdata_ff.arrival) ?
                      new_ff.arrival - rdata_ff.arrival : '0;
            vtime_in = rdata_ff.tag;
            if (count_ff == CNT_W'(1)) begin
               count_in = '0;
               qcount_in = '0;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               rd_en = 1'b1;
               rd_addr = ADDR_W'(1);
               ptr_in = ADDR_W'(1);
               state_in = ST_POP_SHIFT;
            end
         end
         ST_POP_SHIFT: begin
            wr_en = 1'b1;
            wr_addr = ptr_ff - ADDR_W'(1);
            wr_data = rdata_ff;
            if ((CNT_W'(ptr_ff) + CNT_W'(1)) < count_ff) begin
               rd_en = 1'b1;
               rd_addr = ptr_ff + ADDR_W'(1);
               ptr_in = ptr_ff + ADDR_W'(1);
            end else begin
               count_in = count_ff - CNT_W'(1);
               qcount_in = 8'(count_in);
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         vtime_ff <= '0;
         last0_ff <= '0;
         last1_ff <= '0;
         busy_ff <= 1'b0;
         drop_ff <= '0;
         qlimit_ff <= LIMIT_W'(100);
         step0_ff <= STEP_W'(131072);
         step1_ff <= STEP_W'(262144);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         vtime_ff <= vtime_in;
         last0_ff <= last0_in;
         last1_ff <= last1_in;
         busy_ff <= busy_in;
         drop_ff <= drop_in;
         qlimit_ff <= qlimit_in;
         step0_ff <= step0_in;
         step1_ff <= step1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      new_ff <= new_in;
      kind_ff <= kind_in;
      oflow_ff <= oflow_in;
      tag_ff <= tag_in;
      wait_ff <= wait_in;
      qcount_ff <= qcount_in;
      dcount_ff <= dcount_in;
   end

endmodule

// ----- rtl/wfq_tag_scheduler_chk.sv -----
// Port-level checker of the WFQ tag scheduler and the bind that attaches it.
// Depends on wfq_pkg and on the top level wfq_tag_scheduler.
module wfq_tag_scheduler_chk (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  kind,
   input logic        out_flow,
   input logic [31:0] finish_tag,
   input logic [31:0] wait_time,
   input logic [7:0]  queue_count,
   input logic [31:0] dropped_count
);
   import wfq_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(kind) && $stable(finish_tag)
         && $stable(queue_count))
      else $error("Stalled response word changed.");

   a_wait_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind != KIND_DEQUEUED |-> wait_time == '0)
      else $error("Wait time is nonzero on a word that is not a dequeue.");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind == KIND_IDLE |-> queue_count == '0 && finish_tag == '0
         && out_flow == 1'b0)
      else $error("Idle word reports a packet or a waiting queue.");

   a_drop_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind == KIND_DROPPED |-> dropped_count != '0)
      else $error("Dropped word with a zero drop count.");

endmodule

bind wfq_tag_scheduler wfq_tag_scheduler_chk u_chk (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .kind(rsp.kind),
   .out_flow(rsp.out_flow),
   .finish_tag(rsp.finish_tag),
   .wait_time(rsp.wait_time),
   .queue_count(rsp.queue_count),
   .dropped_count(rsp.dropped_count)
);
